// ----- hw/rtl/cms_pkg.sv -----
// Shared types and constants of the curtain motor sequencer.
// Used by every module in hw/rtl; depends on nothing.
`default_nettype none

package cms_pkg;

    // Fixed field widths
    localparam int LUX_W      = 23;
    localparam int TIMER_W    = 18;
    localparam int LOCKOUT_W  = 19;
    localparam int RUN_W      = 8;
    localparam int SECS_W     = 17;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // Motor commands and direction requests share one code space
    localparam logic [1:0] MOT_STOP  = 2'd0;
    localparam logic [1:0] MOT_OPEN  = 2'd1;
    localparam logic [1:0] MOT_CLOSE = 2'd2;

    // Sequence phase
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_CLOSING = 2'd1;
    localparam logic [1:0] PH_OPENING = 2'd2;

    // Operating mode
    localparam logic [1:0] MODE_AUTO   = 2'd1;
    localparam logic [1:0] MODE_MANUAL = 2'd2;

    localparam logic [7:0]        PROX_CLOSED  = 8'hFF;
    localparam logic [SECS_W-1:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [SECS_W-1:0] SEC_PER_MIN  = 17'd60;

    // Register indexes (byte address / 4)
    localparam logic [REG_IDX_W-1:0] REG_LUX_CLOSE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LUX_OPEN  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CLOSE_T   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OPEN_T    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LOCKOUT   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RUN       = 3'd5;

    typedef struct packed {
        logic [1:0]       direction_request;
        logic [1:0]       mode;
        logic [LUX_W-1:0] lux_centi;
        logic [7:0]       proximity;
        logic [4:0]       hour;
        logic [5:0]       minute;
    } t_in_item;

    typedef struct packed {
        logic [1:0] motor_drive;
        logic [1:0] sequence_res;
    } t_out_item;

    typedef struct packed {
        logic [LUX_W-1:0]         lux_close_below;
        logic [LUX_W-1:0]         lux_open_above;
        logic signed [TIMER_W-1:0] close_time_sec;
        logic signed [TIMER_W-1:0] open_time_sec;
        logic [LOCKOUT_W-1:0]     lockout_ticks;
        logic [RUN_W-1:0]         open_run_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0]       last_direction;
        logic [1:0]       phase;
        logic [RUN_W-1:0] run_count;
        logic [1:0]       motor_state;
    } t_core_state;

endpackage

`default_nettype wire

// ----- hw/rtl/cms_cfg_regs.sv -----
// Configuration register file behind the APB-style port.
// Depends on cms_pkg.
`default_nettype none

module cms_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [cms_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [cms_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [cms_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output cms_pkg::t_cfg                       o_cfg
);

    cms_pkg::t_cfg                       r_cfg;
    logic [cms_pkg::REG_IDX_W-1:0]       idx;
    logic                                wr_en;

    assign idx    = paddr[cms_pkg::APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lux_close_below <= 23'd100;
            r_cfg.lux_open_above  <= 23'd1000;
            r_cfg.close_time_sec  <= -18'sd1;
            r_cfg.open_time_sec   <= -18'sd1;
            r_cfg.lockout_ticks   <= 19'd396000;
            r_cfg.open_run_ticks  <= 8'd50;
        end else if (wr_en) begin
            case (idx)
                cms_pkg::REG_LUX_CLOSE: r_cfg.lux_close_below <= pwdata[cms_pkg::LUX_W-1:0];
                cms_pkg::REG_LUX_OPEN:  r_cfg.lux_open_above  <= pwdata[cms_pkg::LUX_W-1:0];
                cms_pkg::REG_CLOSE_T:   r_cfg.close_time_sec  <= pwdata[cms_pkg::TIMER_W-1:0];
                cms_pkg::REG_OPEN_T:    r_cfg.open_time_sec   <= pwdata[cms_pkg::TIMER_W-1:0];
                cms_pkg::REG_LOCKOUT:   r_cfg.lockout_ticks   <= pwdata[cms_pkg::LOCKOUT_W-1:0];
                cms_pkg::REG_RUN:       r_cfg.open_run_ticks  <= pwdata[cms_pkg::RUN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back; timers sign-extend
    always_comb begin
        case (idx)
            cms_pkg::REG_LUX_CLOSE: prdata = 32'(r_cfg.lux_close_below);
            cms_pkg::REG_LUX_OPEN:  prdata = 32'(r_cfg.lux_open_above);
            cms_pkg::REG_CLOSE_T:   prdata = 32'(r_cfg.close_time_sec);
            cms_pkg::REG_OPEN_T:    prdata = 32'(r_cfg.open_time_sec);
            cms_pkg::REG_LOCKOUT:   prdata = 32'(r_cfg.lockout_ticks);
            cms_pkg::REG_RUN:       prdata = 32'(r_cfg.open_run_ticks);
            default:                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cms_step.sv -----
// Next-state logic for one tick: lockout counters, running sequences and start rules.
// Purely combinational; depends on cms_pkg.
`default_nettype none

module cms_step #(
    parameter int LOCKOUT_BITS = 19
) (
    input  wire cms_pkg::t_cfg         i_cfg,
    input  wire cms_pkg::t_in_item     i_item,
    input  wire cms_pkg::t_core_state  i_state,
    input  wire logic [LOCKOUT_BITS-1:0] i_close_since,
    input  wire logic [LOCKOUT_BITS-1:0] i_open_since,
    output cms_pkg::t_core_state       o_state,
    output logic [LOCKOUT_BITS-1:0]    o_close_since,
    output logic [LOCKOUT_BITS-1:0]    o_open_since,
    output cms_pkg::t_out_item         o_result
);

    localparam int CmpW = (LOCKOUT_BITS > cms_pkg::LOCKOUT_W) ? LOCKOUT_BITS
                                                              : cms_pkg::LOCKOUT_W;

    logic [LOCKOUT_BITS-1:0]     close_inc;
    logic [LOCKOUT_BITS-1:0]     open_inc;
    logic                        close_ok;
    logic                        open_ok;
    logic [cms_pkg::SECS_W-1:0]  secs;
    logic [cms_pkg::TIMER_W-1:0] close_diff;
    logic [cms_pkg::TIMER_W-1:0] open_diff;
    logic                        close_hit;
    logic                        open_hit;
    logic                        want_close;
    logic                        want_open;

    // Saturating tick counters since each sequence last started
    assign close_inc = (&i_close_since) ? i_close_since : i_close_since + 1'b1;
    assign open_inc  = (&i_open_since)  ? i_open_since  : i_open_since  + 1'b1;

    assign close_ok = !(CmpW'(close_inc) < CmpW'(i_cfg.lockout_ticks));
    assign open_ok  = !(CmpW'(open_inc)  < CmpW'(i_cfg.lockout_ticks));

    // Seconds of day; a negative difference wraps above one, so only 0 or 1 hits
    assign secs = cms_pkg::SECS_W'(i_item.hour) * cms_pkg::SEC_PER_HOUR
                + cms_pkg::SECS_W'(i_item.minute) * cms_pkg::SEC_PER_MIN;
    assign close_diff = {1'b0, secs} - i_cfg.close_time_sec;
    assign open_diff  = {1'b0, secs} - i_cfg.open_time_sec;
    assign close_hit  = !i_cfg.close_time_sec[cms_pkg::TIMER_W-1]
                        && (close_diff[cms_pkg::TIMER_W-1:1] == '0);
    assign open_hit   = !i_cfg.open_time_sec[cms_pkg::TIMER_W-1]
                        && (open_diff[cms_pkg::TIMER_W-1:1] == '0);

    // Rule selection; a refused close does not fall through to open
    always_comb begin
        want_close = 1'b0;
        want_open  = 1'b0;
        if (i_item.mode == cms_pkg::MODE_AUTO) begin
            if (i_item.lux_centi < i_cfg.lux_close_below) begin
                want_close = 1'b1;
            end else if (i_item.lux_centi > i_cfg.lux_open_above) begin
                want_open = 1'b1;
            end
        end else if (i_item.mode == cms_pkg::MODE_MANUAL) begin
            if (close_hit) begin
                want_close = 1'b1;
            end else if (open_hit) begin
                want_open = 1'b1;
            end
        end
    end

    always_comb begin
        o_state       = i_state;
        o_close_since = close_inc;
        o_open_since  = open_inc;
        case (i_state.phase)
            cms_pkg::PH_CLOSING: begin
                if (i_item.proximity == cms_pkg::PROX_CLOSED) begin
                    o_state.motor_state = cms_pkg::MOT_STOP;
                    o_state.phase       = cms_pkg::PH_IDLE;
                end
            end
            cms_pkg::PH_OPENING: begin
                if (i_state.run_count <= 8'd1) begin
                    o_state.run_count   = '0;
                    o_state.motor_state = cms_pkg::MOT_STOP;
                    o_state.phase       = cms_pkg::PH_IDLE;
                end else begin
                    o_state.run_count = i_state.run_count - 1'b1;
                end
            end
            default: begin
                if (i_item.direction_request != i_state.last_direction) begin
                    o_state.last_direction = i_item.direction_request;
                    // Direction three is recorded but leaves the motor alone
                    if (i_item.direction_request <= cms_pkg::MOT_CLOSE) begin
                        o_state.motor_state = i_item.direction_request;
                    end
                end else if (want_close && close_ok) begin
                    o_state.motor_state = cms_pkg::MOT_CLOSE;
                    o_state.phase       = cms_pkg::PH_CLOSING;
                    o_close_since       = '0;
                end else if (want_open && open_ok) begin
                    o_state.motor_state = cms_pkg::MOT_OPEN;
                    o_state.phase       = cms_pkg::PH_OPENING;
                    o_state.run_count   = i_cfg.open_run_ticks;
                    o_open_since        = '0;
                end
            end
        endcase
    end

    assign o_result.motor_drive  = o_state.motor_state;
    assign o_result.sequence_res = o_state.phase;

endmodule

`default_nettype wire

// ----- hw/rtl/curtain_motor_sequencer_top.sv -----
// Top level of the curtain motor sequencer: item pipeline, sequencer state, config port.
// Depends on cms_pkg, cms_cfg_regs and cms_step.
//
//   channel   direction  handshake                       payload
//   --------  ---------  ------------------------------  ----------------------
//   in        sink       i_in_valid / o_in_stall         i_in_item  (t_in_item)
//   out       source     o_out_valid / i_out_stall       o_out_item (t_out_item)
//   config    slave      psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// Throughput is one tick item per clock while the output is not stalled. The item is
// captured in the input register, then one pass of the step logic updates the
// sequencer state and loads the result register in the same edge.
// Reset (i_rst_n low at a rising edge) empties both registers, puts the motor
// at stop with no sequence running, and marks both lockouts as expired.
// A stall on the output holds the result register; the input register keeps
// filling until it too holds an item, and only then is o_in_stall raised.
// Every tick item yields exactly one result item.
`default_nettype none

module curtain_motor_sequencer_top #(
    parameter int LOCKOUT_BITS = 19
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // tick items in
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire cms_pkg::t_in_item              i_in_item,
    // results out
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output cms_pkg::t_out_item                  o_out_item,
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [cms_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [cms_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [cms_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);

    cms_pkg::t_cfg         cfg;

    // Input register
    logic                  r_in_valid;
    cms_pkg::t_in_item     r_in_item;

    // Result register
    logic                  r_out_valid;
    cms_pkg::t_out_item    r_out_item;

    // Sequencer state and its next value
    cms_pkg::t_core_state  r_state;
    cms_pkg::t_core_state  n_state;
    logic [LOCKOUT_BITS-1:0] r_close_since;
    logic [LOCKOUT_BITS-1:0] n_close_since;
    logic [LOCKOUT_BITS-1:0] r_open_since;
    logic [LOCKOUT_BITS-1:0] n_open_since;
    cms_pkg::t_out_item    n_out_item;

    logic                  out_free;
    logic                  advance;
    logic                  in_take;

    cms_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cms_step #(
        .LOCKOUT_BITS (LOCKOUT_BITS)
    ) u_step (
        .i_cfg         (cfg),
        .i_item        (r_in_item),
        .i_state       (r_state),
        .i_close_since (r_close_since),
        .i_open_since  (r_open_since),
        .o_state       (n_state),
        .o_close_since (n_close_since),
        .o_open_since  (n_open_since),
        .o_result      (n_out_item)
    );

    // The result register can load when it is empty or being drained
    assign out_free   = !r_out_valid || !i_out_stall;
    // Move the held item through the step logic into the result register
    assign advance    = r_in_valid && out_free;
    // Stall only when the input register holds an item that cannot move on
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
    end

    // Commit state exactly once per item, as it enters the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid            <= 1'b0;
            r_state.last_direction <= cms_pkg::MOT_STOP;
            r_state.phase          <= cms_pkg::PH_IDLE;
            r_state.run_count      <= '0;
            r_state.motor_state    <= cms_pkg::MOT_STOP;
            r_close_since          <= '1;
            r_open_since           <= '1;
        end else if (advance) begin
            r_out_valid   <= 1'b1;
            r_state       <= n_state;
            r_close_since <= n_close_since;
            r_open_since  <= n_open_since;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ----- hw/rtl/cms_checker.sv -----
// Port-level checks of the curtain motor sequencer, bound to the top level.
// Depends on cms_pkg and curtain_motor_sequencer_top.
`default_nettype none

module cms_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire cms_pkg::t_out_item  o_out_item
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_out_valid) && $past(i_out_stall)
        |-> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // A running close sequence always drives the motor closed
    a_close_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.sequence_res == cms_pkg::PH_CLOSING)
        |-> o_out_item.motor_drive == cms_pkg::MOT_CLOSE)
        else $error("closing sequence without close drive");

    // A running open sequence always drives the motor open
    a_open_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.sequence_res == cms_pkg::PH_OPENING)
        |-> o_out_item.motor_drive == cms_pkg::MOT_OPEN)
        else $error("opening sequence without open drive");

    // Neither output field ever carries the unused code
    a_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.motor_drive != 2'd3)
                        && (o_out_item.sequence_res != 2'd3))
        else $error("unused output code");

endmodule

bind curtain_motor_sequencer_top cms_checker u_cms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for curtain_motor_sequencer_top: tick items in, motor results out.
// Predicts every result in SystemVerilog and compares it field by field; needs only cms_pkg
// and the RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int SINCE_W     = 19;
    localparam int CYCLE_LIMIT = 500000;

    // Codes that only the testbench needs
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] DIR_UNUSED  = 2'd3;

    // Short local names for the package codes used most
    localparam logic [1:0] MODE_AUTO   = cms_pkg::MODE_AUTO;
    localparam logic [1:0] MODE_MANUAL = cms_pkg::MODE_MANUAL;
    localparam logic [7:0] PROX_CLOSED = cms_pkg::PROX_CLOSED;

    localparam logic [cms_pkg::LUX_W-1:0] LUX_MAX   = '1;
    localparam logic [SINCE_W-1:0]        SINCE_MAX = '1;

    // Clock, reset and block ports
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_stall;
    cms_pkg::t_in_item              i_in_item   = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    cms_pkg::t_out_item             o_out_item;
    logic                           psel        = 1'b0;
    logic                           penable     = 1'b0;
    logic                           pwrite      = 1'b0;
    logic [cms_pkg::APB_ADDR_W-1:0] paddr       = '0;
    logic [cms_pkg::APB_DATA_W-1:0] pwdata      = '0;
    logic [cms_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // Predicted sequencer state and the register copy it runs on
    cms_pkg::t_cfg             cur_cfg;
    logic [1:0]                seen_dir;
    logic [1:0]                seq_phase;
    logic [cms_pkg::RUN_W-1:0] open_left;
    logic [SINCE_W-1:0]        since_close;
    logic [SINCE_W-1:0]        since_open;
    logic [1:0]                motor_cmd;

    // Results still owed by the block, oldest first
    cms_pkg::t_out_item pending_drive[$];

    int          err_cnt    = 0;
    int unsigned clk_cycles = 0;

    // Receiver stall pattern: rotate a 16-bit mask, reload it now and then
    logic [15:0] stall_pat = '0;
    int unsigned stall_age = 0;

    curtain_motor_sequencer_top #(
        .LOCKOUT_BITS(SINCE_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Put the predicted state at its power-on values
    task automatic reset_curtain();
        cur_cfg.lux_close_below = 23'd100;
        cur_cfg.lux_open_above  = 23'd1000;
        cur_cfg.close_time_sec  = -18'sd1;
        cur_cfg.open_time_sec   = -18'sd1;
        cur_cfg.lockout_ticks   = 19'd396000;
        cur_cfg.open_run_ticks  = 8'd50;
        seen_dir    = cms_pkg::MOT_STOP;
        seq_phase   = cms_pkg::PH_IDLE;
        open_left   = '0;
        since_close = SINCE_MAX;
        since_open  = SINCE_MAX;
        motor_cmd   = cms_pkg::MOT_STOP;
    endtask

    // Start a close unless its lockout is still running
    function automatic void start_close();
        if (since_close < cur_cfg.lockout_ticks) return;
        motor_cmd   = cms_pkg::MOT_CLOSE;
        seq_phase   = cms_pkg::PH_CLOSING;
        since_close = '0;
    endfunction

    // Start an open unless its lockout is still running
    function automatic void start_open();
        if (since_open < cur_cfg.lockout_ticks) return;
        motor_cmd  = cms_pkg::MOT_OPEN;
        seq_phase  = cms_pkg::PH_OPENING;
        open_left  = cur_cfg.open_run_ticks;
        since_open = '0;
    endfunction

    // Advance the predicted sequencer by one tick and return the result it yields
    function automatic cms_pkg::t_out_item advance_curtain(input cms_pkg::t_in_item it);
        int                 secs;
        int                 close_at;
        int                 open_at;
        cms_pkg::t_out_item res;
        close_at = $signed(cur_cfg.close_time_sec);
        open_at  = $signed(cur_cfg.open_time_sec);
        if (since_close != SINCE_MAX) since_close++;
        if (since_open != SINCE_MAX) since_open++;

        if (seq_phase == cms_pkg::PH_CLOSING) begin
            // Only the proximity byte matters while closing
            if (it.proximity == PROX_CLOSED) begin
                motor_cmd = cms_pkg::MOT_STOP;
                seq_phase = cms_pkg::PH_IDLE;
            end
        end else if (seq_phase == cms_pkg::PH_OPENING) begin
            // A run length of zero ends like a run length of one
            if (open_left <= 1) begin
                open_left = '0;
                motor_cmd = cms_pkg::MOT_STOP;
                seq_phase = cms_pkg::PH_IDLE;
            end else begin
                open_left--;
            end
        end else if (it.direction_request != seen_dir) begin
            // The unused direction code is remembered but leaves the motor alone
            seen_dir = it.direction_request;
            if (it.direction_request != DIR_UNUSED) motor_cmd = it.direction_request;
        end else if (it.mode == MODE_AUTO) begin
            if (it.lux_centi < cur_cfg.lux_close_below) start_close();
            else if (it.lux_centi > cur_cfg.lux_open_above) start_open();
        end else if (it.mode == MODE_MANUAL) begin
            // Out-of-range hours and minutes still count into the seconds
            secs = int'(it.hour) * int'(cms_pkg::SEC_PER_HOUR)
                 + int'(it.minute) * int'(cms_pkg::SEC_PER_MIN);
            if (close_at >= 0 && secs >= close_at && secs - close_at < 2) start_close();
            else if (open_at >= 0 && secs >= open_at && secs - open_at < 2) start_open();
        end

        res.motor_drive  = motor_cmd;
        res.sequence_res = seq_phase;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic cms_pkg::t_in_item mk_tick(input logic [1:0] dir,
                                                  input logic [1:0] mode,
                                                  input logic [cms_pkg::LUX_W-1:0] lux,
                                                  input logic [7:0] prox,
                                                  input logic [4:0] hour,
                                                  input logic [5:0] minute);
        cms_pkg::t_in_item it;
        it.direction_request = dir;
        it.mode              = mode;
        it.lux_centi         = lux;
        it.proximity         = prox;
        it.hour              = hour;
        it.minute            = minute;
        return it;
    endfunction

    // Build a random tick, mostly one that gets past the direction check and
    // lands on or near a threshold or a programmed time
    function automatic cms_pkg::t_in_item gen_tick();
        cms_pkg::t_in_item it;
        int                aim;
        int                secs;
        int                close_at;
        int                open_at;
        close_at = $signed(cur_cfg.close_time_sec);
        open_at  = $signed(cur_cfg.open_time_sec);

        if ($urandom_range(0, 19) == 0) it.direction_request = 2'($urandom_range(0, 3));
        else it.direction_request = seen_dir;

        case ($urandom_range(0, 9))
            0, 1, 2, 3: it.mode = MODE_AUTO;
            4, 5, 6, 7: it.mode = MODE_MANUAL;
            8:          it.mode = MODE_IDLE;
            default:    it.mode = MODE_UNUSED;
        endcase

        case ($urandom_range(0, 7))
            0: it.lux_centi = '0;
            1: it.lux_centi = LUX_MAX;
            2: it.lux_centi = (cur_cfg.lux_close_below == 0) ? '0 :
                   cms_pkg::LUX_W'($urandom_range(0, int'(cur_cfg.lux_close_below) - 1));
            3: it.lux_centi = (cur_cfg.lux_open_above == LUX_MAX) ? LUX_MAX :
                   cms_pkg::LUX_W'($urandom_range(int'(cur_cfg.lux_open_above) + 1,
                                                  int'(LUX_MAX)));
            4: it.lux_centi = cur_cfg.lux_close_below;
            5: it.lux_centi = cur_cfg.lux_open_above;
            default: it.lux_centi = cms_pkg::LUX_W'($urandom());
        endcase

        case ($urandom_range(0, 5))
            0:       it.proximity = PROX_CLOSED;
            1:       it.proximity = PROX_CLOSED - 8'd1;
            default: it.proximity = 8'($urandom());
        endcase

        // Default time of day, now and then with out-of-range hour and minute
        if ($urandom_range(0, 15) == 0) begin
            it.hour   = 5'($urandom_range(0, 31));
            it.minute = 6'($urandom_range(0, 63));
        end else begin
            it.hour   = 5'($urandom_range(0, 23));
            it.minute = 6'($urandom_range(0, 59));
        end

        // Aim at the first minute boundary at or after a programmed time
        if (it.mode == MODE_MANUAL && $urandom_range(0, 3) != 0) begin
            aim = $urandom_range(0, 1) ? close_at : open_at;
            if (aim < 0) aim = (close_at >= 0) ? close_at : open_at;
            if (aim >= 0) begin
                secs = ((aim + 59) / 60) * 60;
                case ($urandom_range(0, 5))
                    0:       secs += 60;
                    1:       if (secs >= 60) secs -= 60;
                    default: ;
                endcase
                it.hour   = 5'(secs / 3600);
                it.minute = 6'((secs % 3600) / 60);
            end
        end
        return it;
    endfunction

    // Offer one item, hold it until accepted, then record what it should yield
    task automatic send_tick(input cms_pkg::t_in_item it);
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_drive.push_back(advance_curtain(it));
    endtask

    // Drop valid for a number of cycles; zero keeps the burst going
    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every owed result has been taken
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Setup phase, access phase until pready, then a quiet phase with psel low; call only while idle
    task automatic write_reg(input logic [cms_pkg::REG_IDX_W-1:0] idx,
                             input logic [cms_pkg::APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            cms_pkg::REG_LUX_CLOSE:
                cur_cfg.lux_close_below = val[cms_pkg::LUX_W-1:0];
            cms_pkg::REG_LUX_OPEN:
                cur_cfg.lux_open_above  = val[cms_pkg::LUX_W-1:0];
            cms_pkg::REG_CLOSE_T:
                cur_cfg.close_time_sec  = val[cms_pkg::TIMER_W-1:0];
            cms_pkg::REG_OPEN_T:
                cur_cfg.open_time_sec   = val[cms_pkg::TIMER_W-1:0];
            cms_pkg::REG_LOCKOUT:
                cur_cfg.lockout_ticks   = val[cms_pkg::LOCKOUT_W-1:0];
            cms_pkg::REG_RUN:
                cur_cfg.open_run_ticks  = val[cms_pkg::RUN_W-1:0];
            default: ;
        endcase
    endtask

    // Random ticks in bursts of random length, with the odd long burst
    task automatic run_random_ticks(input int count);
        int burst_left;
        burst_left = 0;
        for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                          : $urandom_range(1, 12);
            end
            send_tick(gen_tick());
            burst_left--;
        end
    endtask

    // Timer setting: disabled, on a minute, one second before a minute, or anywhere
    function automatic int pick_timer();
        case ($urandom_range(0, 3))
            0:       return -1;
            1:       return 60 * $urandom_range(0, 1439);
            2:       return 60 * $urandom_range(1, 1440) - 1;
            default: return $urandom_range(0, 86399);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Direction changes, idle modes, both sequences and the manual window edges
    task automatic test_directed();
        // Reset settings: direction requests drive the motor directly
        send_tick(mk_tick(cms_pkg::MOT_OPEN,  MODE_IDLE,   '0,      8'd0, 5'd0,  6'd0));
        send_tick(mk_tick(cms_pkg::MOT_CLOSE, MODE_IDLE,   '0,      8'd0, 5'd0,  6'd0));
        send_tick(mk_tick(DIR_UNUSED,         MODE_IDLE,   '0,      8'd0, 5'd0,  6'd0));
        send_tick(mk_tick(cms_pkg::MOT_STOP,  MODE_IDLE,   '0,      8'd0, 5'd0,  6'd0));
        send_tick(mk_tick(cms_pkg::MOT_STOP,  MODE_UNUSED, '0,      8'd0, 5'd0,  6'd0));
        send_tick(mk_tick(cms_pkg::MOT_STOP,  MODE_IDLE,   LUX_MAX, 8'd0, 5'd23, 6'd59));
        // Close start ignores a closed proximity reading on its own tick
        send_tick(mk_tick(cms_pkg::MOT_STOP, MODE_AUTO, '0,      PROX_CLOSED, 5'd0, 6'd0));
        send_tick(mk_tick(cms_pkg::MOT_OPEN, MODE_AUTO, LUX_MAX, 8'd254,      5'd0, 6'd0));
        send_tick(mk_tick(cms_pkg::MOT_STOP, MODE_AUTO, '0,      PROX_CLOSED, 5'd0, 6'd0));
        // Lockout refuses the second close
        send_tick(mk_tick(cms_pkg::MOT_STOP, MODE_AUTO, '0,      8'd0,        5'd0, 6'd0));
        drain_results();

        // Zero run length, no lockout, timers at 22:00 and one second before 7:30
        write_reg(cms_pkg::REG_RUN, 0);
        write_reg(cms_pkg::REG_LOCKOUT, 0);
        write_reg(cms_pkg::REG_CLOSE_T, 79200);
        write_reg(cms_pkg::REG_OPEN_T, 26999);
        send_tick(mk_tick(cms_pkg::MOT_STOP, MODE_AUTO,   LUX_MAX, 8'd0,        5'd0,  6'd0));
        send_tick(mk_tick(cms_pkg::MOT_STOP, MODE_AUTO,   LUX_MAX, 8'd0,        5'd0,  6'd0));
        send_tick(mk_tick(cms_pkg::MOT_STOP, MODE_MANUAL, '0,      8'd17,       5'd22, 6'd0));
        send_tick(mk_tick(cms_pkg::MOT_STOP, MODE_MANUAL, '0,      PROX_CLOSED, 5'd22, 6'd0));
        send_tick(mk_tick(cms_pkg::MOT_STOP, MODE_MANUAL, '0,      8'd0,        5'd22, 6'd0));
        send_tick(mk_tick(cms_pkg::MOT_STOP, MODE_MANUAL, '0,      PROX_CLOSED, 5'd22, 6'd0));
        send_tick(mk_tick(cms_pkg::MOT_STOP, MODE_MANUAL, '0,      8'd0,        5'd7,  6'd30));
        send_tick(mk_tick(cms_pkg::MOT_STOP, MODE_MANUAL, '0,      8'd0,        5'd7,  6'd30));
        send_tick(mk_tick(cms_pkg::MOT_STOP, MODE_MANUAL, '0,      8'd0,        5'd7,  6'd29));
        send_tick(mk_tick(cms_pkg::MOT_STOP, MODE_MANUAL, '0,      8'd0,        5'd22, 6'd1));
        send_tick(mk_tick(cms_pkg::MOT_STOP, MODE_MANUAL, '0,      8'd0,        5'd31, 6'd63));
        send_tick(mk_tick(DIR_UNUSED,        MODE_MANUAL, '0,      8'd0,        5'd22, 6'd0));
        send_tick(mk_tick(DIR_UNUSED,        MODE_AUTO,   23'd500, 8'd0,        5'd0,  6'd0));
        drain_results();
    endtask

    // Light thresholds at their reset values with no lockout
    task automatic test_auto_light();
        write_reg(cms_pkg::REG_LUX_CLOSE, 100);
        write_reg(cms_pkg::REG_LUX_OPEN, 1000);
        write_reg(cms_pkg::REG_CLOSE_T, -1);
        write_reg(cms_pkg::REG_OPEN_T, -1);
        write_reg(cms_pkg::REG_LOCKOUT, 0);
        write_reg(cms_pkg::REG_RUN, 1);
        run_random_ticks(200);
        drain_results();
    endtask

    // Overlapping thresholds at the extremes: a refused close must not open
    task automatic test_threshold_extremes();
        write_reg(cms_pkg::REG_LUX_CLOSE, int'(LUX_MAX));
        write_reg(cms_pkg::REG_LUX_OPEN, 0);
        write_reg(cms_pkg::REG_LOCKOUT, 300);
        write_reg(cms_pkg::REG_RUN, 255);
        run_random_ticks(300);
        drain_results();
    endtask

    // Manual timers at midnight and at the last second of the day
    task automatic test_manual_timer();
        write_reg(cms_pkg::REG_LUX_CLOSE, 0);
        write_reg(cms_pkg::REG_LUX_OPEN, int'(LUX_MAX));
        write_reg(cms_pkg::REG_CLOSE_T, 0);
        write_reg(cms_pkg::REG_OPEN_T, 86399);
        write_reg(cms_pkg::REG_LOCKOUT, 20);
        write_reg(cms_pkg::REG_RUN, 3);
        run_random_ticks(200);
        drain_results();
    endtask

    // Largest lockout: only a sequence idle since reset may still start
    task automatic test_lockout_max();
        write_reg(cms_pkg::REG_LUX_CLOSE, 5000);
        write_reg(cms_pkg::REG_LUX_OPEN, 5000);
        write_reg(cms_pkg::REG_CLOSE_T, 43200);
        write_reg(cms_pkg::REG_OPEN_T, 43199);
        write_reg(cms_pkg::REG_LOCKOUT, int'(SINCE_MAX));
        write_reg(cms_pkg::REG_RUN, 2);
        run_random_ticks(100);
        drain_results();
    endtask

    // Several random settings, short lockouts and mostly short runs
    task automatic test_random_config();
        int close_at;
        for (int round = 0; round < 3; round++) begin
            write_reg(cms_pkg::REG_LUX_CLOSE, ($urandom_range(0, 3) == 0) ?
                      $urandom_range(0, int'(LUX_MAX)) : $urandom_range(0, 2000));
            write_reg(cms_pkg::REG_LUX_OPEN, ($urandom_range(0, 3) == 0) ?
                      $urandom_range(0, int'(LUX_MAX)) : $urandom_range(0, 2000));
            close_at = pick_timer();
            write_reg(cms_pkg::REG_CLOSE_T, close_at);
            write_reg(cms_pkg::REG_OPEN_T,
                      ($urandom_range(0, 3) == 0) ? close_at : pick_timer());
            write_reg(cms_pkg::REG_LOCKOUT, $urandom_range(0, 40));
            write_reg(cms_pkg::REG_RUN, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                                     : $urandom_range(0, 8));
            run_random_ticks(75);
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker and receiver stall
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        cms_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_drive.size() == 0) begin
                $error("result item with none expected: motor_drive %0d sequence_res %0d",
                       o_out_item.motor_drive, o_out_item.sequence_res);
                err_cnt++;
            end else begin
                want = pending_drive.pop_front();
                if (o_out_item.motor_drive !== want.motor_drive) begin
                    $error("motor_drive: expected %0d, got %0d",
                           want.motor_drive, o_out_item.motor_drive);
                    err_cnt++;
                end
                if (o_out_item.sequence_res !== want.sequence_res) begin
                    $error("sequence_res: expected %0d, got %0d",
                           want.sequence_res, o_out_item.sequence_res);
                    err_cnt++;
                end
            end
        end

        // Reload the stall mask at random intervals: none, sparse, dense or even
        if (stall_age == 0) begin
            case ($urandom_range(0, 3))
                0:       stall_pat <= '0;
                1:       stall_pat <= 16'($urandom() & $urandom());
                2:       stall_pat <= 16'($urandom() | $urandom());
                default: stall_pat <= 16'($urandom());
            endcase
            stall_age <= $urandom_range(16, 200);
        end else begin
            stall_pat <= {stall_pat[0], stall_pat[15:1]};
            stall_age <= stall_age - 1;
        end
        i_out_stall <= stall_pat[0];
    end

    // Watchdog
    always @(posedge i_clk) begin
        clk_cycles <= clk_cycles + 1;
        if (clk_cycles == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        reset_curtain();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_auto_light();
        test_threshold_extremes();
        test_manual_timer();
        test_lockout_max();
        test_random_config();

        // Let the last results through, then allow for the pipeline depth
        i_in_valid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_drive.size() != 0) begin
            $error("%0d result items never arrived", pending_drive.size());
            err_cnt++;
        end

        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
